// ===== design/sm4r_pkg.sv =====
// ----------------------------------------------------------------------------
// SM4 rounds package
// Shared types, constants and the SM4 round function T (S-box and L).
// ----------------------------------------------------------------------------
package sm4r_pkg;

  localparam int KEY_IDX_W    = 5;
  localparam int WORD_W       = 32;
  localparam int BLOCK_W      = 128;
  localparam int HALF_W       = 64;
  localparam int KEY_DEPTH    = 32;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = 1;
  localparam int QCNT_W       = 2;

  typedef enum logic {
    OP_KEY   = 1'b0,
    OP_BLOCK = 1'b1
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [KEY_IDX_W-1:0] key_index;
    logic [WORD_W-1:0]    round_key;
    logic [BLOCK_W-1:0]   block;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [WORD_W-1:0] sm4r_t_f(logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] b;
    b = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

endpackage

// ===== design/sm4r_if.sv =====
// ----------------------------------------------------------------------------
// SM4 rounds channel interfaces
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface sm4r_cmd_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [4:0]  key_index;
  logic [31:0] round_key;
  logic [63:0] block_high;
  logic [63:0] block_low;

  modport source (output valid, action, key_index, round_key, block_high, block_low,
                  input ready);
  modport sink   (input valid, action, key_index, round_key, block_high, block_low,
                  output ready);
endinterface

interface sm4r_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

// ===== design/sm4r_front.sv =====
// ----------------------------------------------------------------------------
// SM4 rounds front end
// Accepts command beats, classifies them and registers them for the queue.
// ----------------------------------------------------------------------------
module sm4r_front import sm4r_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  sm4r_cmd_if.sink        cmd_i,
  input  logic            push_ready_i,
  output logic            push_valid_o,
  output cmd_t            push_cmd_o
);

  logic vld_q;
  cmd_t cmd_q;
  cmd_t cmd_d;
  logic accept;

  assign cmd_i.ready = !vld_q || push_ready_i;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    cmd_d           = cmd_q;
    cmd_d.op        = cmd_i.action ? OP_BLOCK : OP_KEY;
    cmd_d.key_index = cmd_i.key_index;
    cmd_d.round_key = cmd_i.round_key;
    if (cmd_i.action) begin
      cmd_d.block = {cmd_i.block_high, cmd_i.block_low};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign push_valid_o = vld_q;
  assign push_cmd_o   = cmd_q;

endmodule

// ===== design/sm4r_queue.sv =====
// ----------------------------------------------------------------------------
// SM4 rounds command queue
// Short queue that decouples the front end from the round engine.
// ----------------------------------------------------------------------------
module sm4r_queue import sm4r_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  input  cmd_t        push_cmd_i,
  output logic        push_ready_o,
  output queue_head_t head_o,
  input  logic        pop_i
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push;
  logic              pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign head_o.valid = cnt_q != '0;
  assign head_o.cmd   = mem_q[rd_ptr_q];

endmodule

// ===== design/sm4r_back.sv =====
// ----------------------------------------------------------------------------
// SM4 rounds engine
// Holds the round key table and runs one shared round per cycle, holding the last round while the result is not taken.
// ----------------------------------------------------------------------------
module sm4r_back import sm4r_pkg::*; #(
  parameter int NUM_ROUNDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_head_t head_i,
  output logic        pop_o,
  sm4r_res_if.source  res_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e               state_q;
  logic [KEY_IDX_W-1:0] cnt_q;
  logic [BLOCK_W-1:0]   w_q;
  logic                 out_vld_q;
  logic [HALF_W-1:0]    res_high_q;
  logic [HALF_W-1:0]    res_low_q;
  logic [WORD_W-1:0]    key_tbl_q [KEY_DEPTH];

  logic [WORD_W-1:0]    w0, w1, w2, w3;
  logic [WORD_W-1:0]    nw;
  logic                 last;
  logic                 out_free;
  logic                 finish;

  assign w0       = w_q[127:96];
  assign w1       = w_q[95:64];
  assign w2       = w_q[63:32];
  assign w3       = w_q[31:0];
  assign nw       = w0 ^ sm4r_t_f(w1 ^ w2 ^ w3 ^ key_tbl_q[cnt_q]);
  assign last     = cnt_q == KEY_IDX_W'(NUM_ROUNDS - 1);
  assign out_free = !out_vld_q || res_o.ready;
  assign finish   = (state_q == ST_RUN) && last && out_free;
  assign pop_o    = (state_q == ST_IDLE) && head_i.valid;

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.cmd.op == OP_KEY) begin
      key_tbl_q[head_i.cmd.key_index] <= head_i.cmd.round_key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      w_q        <= '0;
      out_vld_q  <= 1'b0;
      res_high_q <= '0;
      res_low_q  <= '0;
    end else begin
      if (finish) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o && head_i.cmd.op == OP_BLOCK) begin
            w_q     <= head_i.cmd.block;
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!last) begin
            w_q   <= {w1, w2, w3, nw};
            cnt_q <= cnt_q + KEY_IDX_W'(1);
          end else if (out_free) begin
            w_q        <= {w1, w2, w3, nw};
            res_high_q <= {nw, w3};
            res_low_q  <= {w2, w1};
            cnt_q      <= '0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.result_high = res_high_q;
  assign res_o.result_low  = res_low_q;

endmodule

// ===== design/sm4_block_cipher_rounds_unit.sv =====
// Blocks run one at a time through the single shared round unit.
// Key-load beats pass the queue and retire one per cycle while the engine is idle.
// Reset is asynchronous and clears the control state, the word and result registers.
// The round key table is not cleared and must be written before use.
// ----------------------------------------------------------------------------
// SM4 block cipher rounds unit
// Front end, command queue and round engine for 32-round SM4 block processing.
// ----------------------------------------------------------------------------
module sm4_block_cipher_rounds_unit import sm4r_pkg::*; #(
  parameter int NUM_ROUNDS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sm4r_cmd_if.sink   cmd_i,
  sm4r_res_if.source res_o
);

  logic        push_valid;
  logic        push_ready;
  cmd_t        push_cmd;
  queue_head_t head;
  logic        pop;

  sm4r_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  sm4r_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  sm4r_back #(
    .NUM_ROUNDS (NUM_ROUNDS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

// ===== design/sm4r_checker.sv =====
// ----------------------------------------------------------------------------
// SM4 rounds port checker
// Checks the result channel and the block/result balance seen at the ports.
// ----------------------------------------------------------------------------
module sm4r_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_high_i,
  input logic [63:0] out_low_i
);

  logic [3:0] pending_q;
  logic       blk_acc;
  logic       res_acc;

  assign blk_acc = in_valid_i && in_ready_i && in_action_i;
  assign res_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (blk_acc && !res_acc) begin
      pending_q <= pending_q + 4'd1;
    end else if (res_acc && !blk_acc) begin
      pending_q <= pending_q - 4'd1;
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result beat withdrawn before it was taken.");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_high_i) && $stable(out_low_i))
    else $error("Stalled result beat changed.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 4'd0)
    else $error("Result beat without an outstanding block.");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'd5)
    else $error("More blocks outstanding than the unit can hold.");

endmodule

bind sm4_block_cipher_rounds_unit sm4r_checker u_sm4r_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .in_action_i (cmd_i.action),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_high_i  (res_o.result_high),
  .out_low_i   (res_o.result_low)
);
